### design/running_median_two_heaps_assert.svh
// Assertion macros for the checker file rmth_chk.sv.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RMTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rmth: check failed");

// next-cycle implication, disabled while reset is asserted
`define RMTH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rmth: check failed");

`endif

### design/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg
// Types and constants for the two-heap running median block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmth_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MED_W    = 33;
  localparam int HELD_W   = 11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PP_CHK,
    ST_SD_L,
    ST_SD_LD,
    ST_SD_RD,
    ST_SD_MV,
    ST_PU_START,
    ST_PU_D,
    ST_PU_W,
    ST_NXT,
    ST_FIN
  } state_t;

  // heap operation in progress
  typedef enum logic [1:0] {
    OP_UPP,    // push-pop on upper heap
    OP_LPP,    // push-pop on lower heap
    OP_PUSHU,  // push to upper heap
    OP_PUSHL   // push to lower heap
  } op_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic                       is_max;
  } cmp_req_t;

endpackage

`default_nettype wire

### design/rmth_ram.sv
// ----------------------------------------------------------------------------
// rmth_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/rmth_cmp.sv
// ----------------------------------------------------------------------------
// rmth_cmp
// Shared heap-order comparator: larger wins for max-heap, smaller for min-heap.
// ----------------------------------------------------------------------------
`default_nettype none

module rmth_cmp
  import rmth_pkg::*;
(
  input  wire cmp_req_t req,
  output logic          outranks
);

  assign outranks = req.is_max ? (req.a > req.b) : (req.a < req.b);

endmodule

`default_nettype wire

### design/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median of signed 32-bit samples kept in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_sample with start high; the item is taken at an edge where busy
//   is low. busy stays high while the sequencer works on that item.
//   One result per item: out_valid pulses for one cycle with twice the median,
//   the held count and the reject flag. The receiver cannot stall; the result
//   is registered and shown while the block is already idle again.
// Sequence:
//   A rejected item (store full) goes straight to the result. Otherwise an item
//   runs one or two push-pops and one push on the heap RAMs, all through one
//   shared comparator. Each sift-down level reads one or two children through
//   the registered RAM port, then does a move; each sift-up level is one
//   compare-and-move after a start step, and a dispatch step runs between the
//   heap operations. The longest item runs two sift-downs and a sift-up across
//   the full heap height.
// Reset:
//   Synchronous active-low reset empties both heaps (counts to zero); heap
//   RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                            out_valid,
  output logic signed [MED_W-1:0]         out_median_doubled,
  output logic [HELD_W-1:0]               out_held_count,
  output logic                            out_rejected
);

  localparam int LDEPTH = (CAPACITY + 1) / 2;
  localparam int UDEPTH = CAPACITY / 2;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int UAW    = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
  localparam int CW     = $clog2(LDEPTH + 1);
  localparam int HW     = CW + 1;
  localparam int IW     = LAW + 2;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic signed [SAMPLE_W-1:0] v_r, v_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;
  logic signed [SAMPLE_W-1:0] bestv_r, bestv_nxt;
  logic signed [SAMPLE_W-1:0] ltop_r, ltop_nxt;
  logic signed [SAMPLE_W-1:0] utop_r, utop_nxt;
  logic [LAW-1:0]             i_r, i_nxt;
  logic [LAW-1:0]             best_r, best_nxt;
  logic                       bmove_r, bmove_nxt;
  logic [CW-1:0]              lcnt_r, lcnt_nxt;
  logic [CW-1:0]              ucnt_r, ucnt_nxt;
  logic                       rej_r, rej_nxt;

  logic                       out_valid_nxt;
  logic signed [MED_W-1:0]    out_med_nxt;
  logic [HELD_W-1:0]          out_held_nxt;
  logic                       out_rej_nxt;

  logic                       upper;
  logic [CW-1:0]              hcnt;
  logic signed [SAMPLE_W-1:0] htop;
  logic [HW-1:0]              held;
  logic                       full;
  logic [IW-1:0]              lw, rw, cntw;
  logic [LAW-1:0]             par_i, par_p, par_c;

  logic                       we;
  logic [LAW-1:0]             waddr, raddr;
  logic signed [SAMPLE_W-1:0] wdata;
  logic signed [SAMPLE_W-1:0] l_rdata, u_rdata, rdata;

  cmp_req_t                   creq;
  logic                       ot;

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(LDEPTH), .AW(LAW)) u_lower_ram (
    .clk   (clk),
    .we    (we && !upper),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (l_rdata)
  );

  rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(UDEPTH), .AW(UAW)) u_upper_ram (
    .clk   (clk),
    .we    (we && upper),
    .waddr (waddr[UAW-1:0]),
    .wdata (wdata),
    .raddr (raddr[UAW-1:0]),
    .rdata (u_rdata)
  );

  rmth_cmp u_cmp (
    .req      (creq),
    .outranks (ot)
  );

  assign upper = (op_r == OP_UPP) || (op_r == OP_PUSHU);
  assign hcnt  = upper ? ucnt_r : lcnt_r;
  assign htop  = upper ? utop_r : ltop_r;
  assign rdata = upper ? u_rdata : l_rdata;
  assign held  = HW'(lcnt_r) + HW'(ucnt_r);
  assign full  = held >= HW'(CAPACITY);
  assign lw    = IW'({i_r, 1'b1});
  assign rw    = lw + IW'(1);
  assign cntw  = IW'(hcnt);
  assign par_i = (i_r - LAW'(1)) >> 1;
  assign par_p = (par_i - LAW'(1)) >> 1;
  assign par_c = (hcnt[LAW-1:0] - LAW'(1)) >> 1;
  assign busy  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      op_r      <= OP_UPP;
      lcnt_r    <= '0;
      ucnt_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      lcnt_r    <= lcnt_nxt;
      ucnt_r    <= ucnt_nxt;
      out_valid <= out_valid_nxt;
    end
    v_r                <= v_nxt;
    res_r              <= res_nxt;
    bestv_r            <= bestv_nxt;
    ltop_r             <= ltop_nxt;
    utop_r             <= utop_nxt;
    i_r                <= i_nxt;
    best_r             <= best_nxt;
    bmove_r            <= bmove_nxt;
    rej_r              <= rej_nxt;
    out_median_doubled <= out_med_nxt;
    out_held_count     <= out_held_nxt;
    out_rejected       <= out_rej_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    bestv_nxt     = bestv_r;
    i_nxt         = i_r;
    best_nxt      = best_r;
    bmove_nxt     = bmove_r;
    lcnt_nxt      = lcnt_r;
    ucnt_nxt      = ucnt_r;
    rej_nxt       = rej_r;
    out_valid_nxt = 1'b0;
    out_med_nxt   = out_median_doubled;
    out_held_nxt  = out_held_count;
    out_rej_nxt   = out_rejected;
    we            = 1'b0;
    waddr         = i_r;
    wdata         = v_r;
    raddr         = '0;
    creq.a        = v_r;
    creq.b        = v_r;
    creq.is_max   = !upper;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (full) begin
            rej_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            rej_nxt   = 1'b0;
            v_nxt     = in_sample;
            op_nxt    = OP_UPP;
            state_nxt = ST_PP_CHK;
          end
        end
      end
      ST_PP_CHK: begin
        creq.a = htop;
        creq.b = v_r;
        if (hcnt == '0 || !ot) begin
          res_nxt   = v_r;
          state_nxt = ST_NXT;
        end else begin
          // top leaves; new value sifts down from the root
          res_nxt   = htop;
          i_nxt     = '0;
          state_nxt = ST_SD_L;
        end
      end
      ST_SD_L: begin
        if (lw < cntw) begin
          raddr     = lw[LAW-1:0];
          state_nxt = ST_SD_LD;
        end else begin
          we        = 1'b1;
          state_nxt = ST_NXT;
        end
      end
      ST_SD_LD: begin
        creq.a = rdata;
        creq.b = v_r;
        if (ot) begin
          best_nxt  = lw[LAW-1:0];
          bestv_nxt = rdata;
          bmove_nxt = 1'b1;
        end else begin
          bestv_nxt = v_r;
          bmove_nxt = 1'b0;
        end
        if (rw < cntw) begin
          raddr     = rw[LAW-1:0];
          state_nxt = ST_SD_RD;
        end else begin
          state_nxt = ST_SD_MV;
        end
      end
      ST_SD_RD: begin
        creq.a = rdata;
        creq.b = bestv_r;
        if (ot) begin
          best_nxt  = rw[LAW-1:0];
          bestv_nxt = rdata;
          bmove_nxt = 1'b1;
        end
        state_nxt = ST_SD_MV;
      end
      ST_SD_MV: begin
        we = 1'b1;
        if (!bmove_r) begin
          state_nxt = ST_NXT;
        end else begin
          wdata     = bestv_r;
          i_nxt     = best_r;
          state_nxt = ST_SD_L;
        end
      end
      ST_PU_START: begin
        i_nxt = hcnt[LAW-1:0];
        if (upper) begin
          ucnt_nxt = ucnt_r + CW'(1);
        end else begin
          lcnt_nxt = lcnt_r + CW'(1);
        end
        if (hcnt == '0) begin
          we        = 1'b1;
          waddr     = '0;
          state_nxt = ST_NXT;
        end else begin
          raddr     = par_c;
          state_nxt = ST_PU_D;
        end
      end
      ST_PU_D: begin
        creq.a = v_r;
        creq.b = rdata;
        we     = 1'b1;
        if (ot) begin
          // parent moves down into the hole
          wdata = rdata;
          i_nxt = par_i;
          if (par_i == '0) begin
            state_nxt = ST_PU_W;
          end else begin
            raddr = par_p;
          end
        end else begin
          state_nxt = ST_NXT;
        end
      end
      ST_PU_W: begin
        we        = 1'b1;
        state_nxt = ST_NXT;
      end
      ST_NXT: begin
        unique case (op_r) inside
          OP_UPP: begin
            v_nxt = res_r;
            if (lcnt_r > ucnt_r) begin
              op_nxt    = OP_LPP;
              state_nxt = ST_PP_CHK;
            end else begin
              op_nxt    = OP_PUSHL;
              state_nxt = ST_PU_START;
            end
          end
          OP_LPP: begin
            v_nxt     = res_r;
            op_nxt    = OP_PUSHU;
            state_nxt = ST_PU_START;
          end
          OP_PUSHU, OP_PUSHL: begin
            state_nxt = ST_FIN;
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_rej_nxt   = rej_r;
        out_held_nxt  = HELD_W'(held);
        if (lcnt_r == '0) begin
          out_med_nxt = '0;
        end else if (lcnt_r == ucnt_r) begin
          out_med_nxt = {ltop_r[SAMPLE_W-1], ltop_r} + {utop_r[SAMPLE_W-1], utop_r};
        end else begin
          out_med_nxt = {ltop_r, 1'b0};
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // shadow copies of the heap roots
    ltop_nxt = ltop_r;
    utop_nxt = utop_r;
    if (we && waddr == '0) begin
      if (upper) begin
        utop_nxt = wdata;
      end else begin
        ltop_nxt = wdata;
      end
    end
  end

endmodule

`default_nettype wire

### design/rmth_chk.sv
// ----------------------------------------------------------------------------
// rmth_chk
// Port-level checks for the running median block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_median_two_heaps_assert.svh"

module rmth_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // result strobe only shows once the item is done
  `RMTH_ASSERT_IMP(a_valid_idle, clk, rst_n, out_valid, !busy)
  // a taken item makes the block busy
  `RMTH_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy)
  // one result per item, single-cycle pulse
  `RMTH_ASSERT_NXT(a_single_pulse, clk, rst_n, out_valid, !out_valid)

endmodule

bind running_median_two_heaps rmth_chk u_rmth_chk (.*);

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives samples through the two-heap running median block and checks each
// result against a sorted-array median predictor kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import rmth_pkg::*;

  localparam int CAP = 1024;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic signed [MED_W-1:0]    out_median_doubled;
  logic [HELD_W-1:0]          out_held_count;
  logic                       out_rejected;

  typedef struct {
    logic signed [MED_W-1:0] median_doubled;
    logic [HELD_W-1:0]       held_count;
    logic                    rejected;
  } median_res_t;

  logic signed [SAMPLE_W-1:0] sample_q[$];
  median_res_t                median_exp_q[$];
  logic signed [SAMPLE_W-1:0] held_sorted[$];
  int                         err_cnt;
  int                         burst_left;
  int                         gap_left;
  bit                         stim_done;

  running_median_two_heaps #(.CAPACITY(CAP)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_median_doubled (out_median_doubled),
    .out_held_count     (out_held_count),
    .out_rejected       (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sorted insert; the median of the sorted set equals what the heaps give
  function automatic median_res_t predict_median(logic signed [SAMPLE_W-1:0] s);
    median_res_t r;
    int n;
    int pos;
    r.rejected = 1'b0;
    if (held_sorted.size() >= CAP) begin
      r.rejected = 1'b1;
    end else begin
      pos = 0;
      while (pos < held_sorted.size() && held_sorted[pos] <= s) pos++;
      held_sorted.insert(pos, s);
    end
    n = held_sorted.size();
    r.held_count = n[HELD_W-1:0];
    if (n % 2 == 1)
      r.median_doubled = MED_W'(held_sorted[n/2]) <<< 1;
    else
      r.median_doubled = MED_W'(held_sorted[n/2-1]) + MED_W'(held_sorted[n/2]);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (start && !busy) begin
      median_exp_q.insert(median_exp_q.size(), predict_median(in_sample));
      void'(sample_q.pop_front());
      if (sample_q.size() > 0 && burst_left > 0) begin
        in_sample  <= sample_q[0];
        burst_left <= burst_left - 1;
      end else begin
        start    <= 1'b0;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      end
    end else if (!start && sample_q.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        start      <= 1'b1;
        in_sample  <= sample_q[0];
        burst_left <= $urandom_range(0, 20);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    median_res_t e;
    if (rst_n && out_valid) begin
      if (median_exp_q.size() == 0) begin
        report_mismatch("unexpected result", out_held_count, -1);
      end else begin
        e = median_exp_q.pop_front();
        if (out_median_doubled !== e.median_doubled)
          report_mismatch("median_doubled", out_median_doubled, e.median_doubled);
        if (out_held_count !== e.held_count)
          report_mismatch("held_count", out_held_count, e.held_count);
        if (out_rejected !== e.rejected)
          report_mismatch("rejected", out_rejected, e.rejected);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 15) - 8;
      2: return {1'b0, {31{1'b1}}} - $urandom_range(0, 3);
      3: return {1'b1, 31'b0} + $urandom_range(0, 3);
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  initial begin
    int i;
    err_cnt   = 0;
    stim_done = 0;
    start     = 1'b0;
    in_sample = '0;
    rst_n     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, ties, sign bit patterns
    sample_q.insert(sample_q.size(), {1'b0, {31{1'b1}}});
    sample_q.insert(sample_q.size(), {1'b0, {31{1'b1}}});
    sample_q.insert(sample_q.size(), {1'b1, 31'b0});
    sample_q.insert(sample_q.size(), {1'b1, 31'b0});
    sample_q.insert(sample_q.size(), {1'b1, 31'b0});
    sample_q.insert(sample_q.size(), 0);
    sample_q.insert(sample_q.size(), -1);
    sample_q.insert(sample_q.size(), 1);
    sample_q.insert(sample_q.size(), 32'h5555_5555);
    sample_q.insert(sample_q.size(), 32'hAAAA_AAAA);
    sample_q.insert(sample_q.size(), 7);
    sample_q.insert(sample_q.size(), 7);
    sample_q.insert(sample_q.size(), 7);
    // random mix of small, wide and extreme samples
    for (i = 0; i < 937; i++) sample_q.insert(sample_q.size(), rand_sample());
    wait (sample_q.size() == 0 && !start);
    wait (median_exp_q.size() == 0);
    repeat (100) @(posedge clk);
    if (err_cnt == 0)
      $display("running_median_two_heaps verification clean");
    else
      $display("running_median_two_heaps verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("running_median_two_heaps verification failed");
    $finish;
  end

endmodule

### running_median_two_heaps.f
+incdir+design
design/rmth_pkg.sv
design/rmth_ram.sv
design/rmth_cmp.sv
design/running_median_two_heaps.sv
design/rmth_chk.sv
verif/tb.sv
